// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, idle during reset
`define SDA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SDA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SDA_ASSERT_IMP(label, ante, cons)
`define SDA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/sda_pkg.sv
// ----------------------------------------------------------------------------
// sda_pkg
// Types, constants and helpers for the surface area accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package sda_pkg;

    localparam int OPND_W = 64;
    localparam int ACC_W  = 128;
    localparam int TOT_W  = 63;
    localparam int LEN_W  = 64;
    localparam int G_W    = 56;

    localparam logic [TOT_W-1:0] SAT_TOTAL = {TOT_W{1'b1}};

    // register indexes
    localparam logic [2:0] REG_EW_RES   = 3'd0;
    localparam logic [2:0] REG_NS_RES   = 3'd1;
    localparam logic [2:0] REG_V_SCALE  = 3'd2;
    localparam logic [2:0] REG_ROW_LEN  = 3'd3;
    localparam logic [2:0] REG_ROW_CNT  = 3'd4;

    // request to the shared multiplier
    typedef struct packed {
        logic start;
        logic accumulate;
    } mul_req_t;

    // |a - b| of two signed samples
    function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? 16'(-d) : d[15:0];
    endfunction

    // saturating add into a Q47.16 total
    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] t,
                                                 input logic [G_W-1:0] a);
        logic [TOT_W:0] s;
        s = {1'b0, t} + (TOT_W+1)'(a);
        return s[TOT_W] ? SAT_TOTAL : s[TOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sda_mul.sv
// ----------------------------------------------------------------------------
// sda_mul
// 64x64 multiply from four 32x32 partial products, clear or accumulate.
// ----------------------------------------------------------------------------
`default_nettype none
module sda_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sda_pkg::mul_req_t             req,
    input  wire logic [sda_pkg::OPND_W-1:0]    a,
    input  wire logic [sda_pkg::OPND_W-1:0]    b,
    output logic [sda_pkg::ACC_W-1:0]          acc,
    output logic                               done
);
    import sda_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [63:0]      p_reg;
    logic [1:0]       sh_reg;
    logic             pv_reg;
    logic [2:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [31:0]      op_a;
    logic [31:0]      op_b;
    logic [1:0]       op_sh;
    logic [ACC_W-1:0] p_shifted;

    // partial product select
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                op_a = a[31:0];  op_b = b[31:0];  op_sh = 2'd0;
            end
            2'd1:
            begin
                op_a = a[31:0];  op_b = b[63:32]; op_sh = 2'd1;
            end
            2'd2:
            begin
                op_a = a[63:32]; op_b = b[31:0];  op_sh = 2'd1;
            end
            default:
            begin
                op_a = a[63:32]; op_b = b[63:32]; op_sh = 2'd2;
            end
        endcase
    end

    assign p_shifted = {64'd0, p_reg} << {sh_reg, 5'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            p_reg    <= '0;
            sh_reg   <= '0;
            pv_reg   <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            if (!req.accumulate)
                acc_reg <= '0;
            pv_reg   <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (pv_reg)
                    acc_reg <= acc_reg + p_shifted;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    pv_reg   <= 1'b0;
                end
                else
                begin
                    p_reg   <= op_a * op_b;
                    sh_reg  <= op_sh;
                    pv_reg  <= 1'b1;
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// File: hw/rtl/sda_sqrt.sv
// ----------------------------------------------------------------------------
// sda_sqrt
// Integer square root of a 128-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sda_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sda_pkg::ACC_W-1:0]     radicand,
    output logic [sda_pkg::LEN_W-1:0]          root,
    output logic                               done
);
    import sda_pkg::*;

    logic [ACC_W-1:0] rad_reg;
    logic [67:0]      rem_reg;
    logic [LEN_W-1:0] root_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [67:0]      rem_sh;
    logic [67:0]      trial;

    // restoring step: bring down two bits, try root*4+1
    assign rem_sh = {rem_reg[65:0], rad_reg[ACC_W-1:ACC_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                rad_reg <= {rad_reg[ACC_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[LEN_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// File: hw/rtl/dem_surface_area_accumulator.sv
// A sample that closes no quad passes S_IDLE, S_READ and S_FIN; one that
// closes a quad also runs 20 products on the shared multiplier and the
// 64-step square root (4 roots per quad) before S_SUM and S_TOTAL.
// A new sample is taken only after the last is through; ready only while idle.
// Reset: asynchronous active low; registers take their defaults, totals and
// indices clear; the line store is not cleared (written before quads use it).
// ----------------------------------------------------------------------------
// dem_surface_area_accumulator
// Surface area of an elevation raster by two triangulations per quad.
// ----------------------------------------------------------------------------
`default_nettype none
module dem_surface_area_accumulator #(
    parameter int MAX_COLS = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [15:0]            elevation,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sda_pkg::TOT_W-1:0]          low_area,
    output logic [sda_pkg::TOT_W-1:0]          high_area,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [23:0]                   cfg_data
);
    import sda_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int LW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_MUL_GO, S_MUL_WAIT, S_SQ_GO, S_SQ_WAIT,
        S_SUM, S_TOTAL, S_FIN
    } state_t;

    state_t            state_reg;
    logic [23:0]       ew_reg;
    logic [23:0]       nsr_reg;
    logic [15:0]       vs_reg;
    logic [12:0]       rl_reg;
    logic [15:0]       rc_reg;
    logic signed [15:0] ul_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] cur_reg;
    logic signed [15:0] line_rd_reg;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     c_reg;
    logic [15:0]       row_reg;
    logic [TOT_W-1:0]  low_total_reg;
    logic [TOT_W-1:0]  high_total_reg;
    logic [TOT_W-1:0]  low_out_reg;
    logic [TOT_W-1:0]  high_out_reg;
    logic              out_valid_reg;
    logic [15:0]       da_reg, db_reg, dc_reg, dd_reg;
    logic [2:0]        mstep_reg;
    logic [1:0]        tri_reg;
    logic [39:0]       nsv_reg;
    logic [39:0]       esv_reg;
    logic [47:0]       en_reg;
    logic [95:0]       czsq_reg;
    logic [OPND_W-1:0] cx_reg;
    logic [OPND_W-1:0] cy_reg;
    logic [LEN_W-1:0]  len_reg [4];
    logic [G_W-1:0]    g1_reg;
    logic [G_W-1:0]    g2_reg;

    logic signed [15:0] line_mem [MAX_COLS];

    logic [LW-1:0]     len_eff;
    logic [15:0]       rows_eff;
    logic [CW-1:0]     c_comb;
    logic              accept;
    logic              last_col;
    logic              last_row;
    logic [15:0]       drow;
    logic [15:0]       dcol;
    logic [OPND_W-1:0] mul_a;
    logic [OPND_W-1:0] mul_b;
    mul_req_t          mul_req;
    logic [ACC_W-1:0]  mul_acc;
    logic              mul_done;
    logic [LEN_W-1:0]  sq_root;
    logic              sq_done;
    logic [LEN_W:0]    sum1;
    logic [LEN_W:0]    sum2;

    // effective geometry
    always_comb
    begin
        if (rl_reg < 13'd2)
            len_eff = LW'(2);
        else if (32'(rl_reg) > MAX_COLS)
            len_eff = LW'(MAX_COLS);
        else
            len_eff = LW'(rl_reg);
        rows_eff = (rc_reg < 16'd2) ? 16'd2 : rc_reg;
    end

    assign c_comb   = ({1'b0, col_reg} >= len_eff) ? '0 : col_reg;
    assign accept   = in_valid && in_ready;
    assign last_col = (LW'(c_reg) + LW'(1)) >= len_eff;
    assign last_row = (17'(row_reg) + 17'd1) >= 17'(rows_eff);

    // triangle edges: T0 (dA,dB) T1 (dC,dD) T2 (dA,dD) T3 (dC,dB)
    assign drow = tri_reg[0] ? dc_reg : da_reg;
    assign dcol = (tri_reg == 2'd0 || tri_reg == 2'd3) ? db_reg : dd_reg;

    // multiplier operand select
    always_comb
    begin
        case (mstep_reg)
            3'd0:
            begin
                mul_a = 64'(nsr_reg); mul_b = 64'(vs_reg);
            end
            3'd1:
            begin
                mul_a = 64'(ew_reg);  mul_b = 64'(vs_reg);
            end
            3'd2:
            begin
                mul_a = 64'(ew_reg);  mul_b = 64'(nsr_reg);
            end
            3'd3:
            begin
                mul_a = 64'(en_reg);  mul_b = 64'(en_reg);
            end
            3'd4:
            begin
                mul_a = 64'(nsv_reg); mul_b = 64'(drow);
            end
            3'd5:
            begin
                mul_a = 64'(esv_reg); mul_b = 64'(dcol);
            end
            3'd6:
            begin
                mul_a = cx_reg;       mul_b = cx_reg;
            end
            default:
            begin
                mul_a = cy_reg;       mul_b = cy_reg;
            end
        endcase
    end

    assign mul_req.start      = (state_reg == S_MUL_GO);
    assign mul_req.accumulate = (mstep_reg == 3'd7);

    sda_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a     (mul_a),
        .b     (mul_b),
        .acc   (mul_acc),
        .done  (mul_done)
    );

    sda_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQ_GO),
        .radicand (mul_acc + {32'd0, czsq_reg}),
        .root     (sq_root),
        .done     (sq_done)
    );

    assign sum1 = {1'b0, len_reg[0]} + {1'b0, len_reg[1]};
    assign sum2 = {1'b0, len_reg[2]} + {1'b0, len_reg[3]};

    // line store
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            line_mem[c_reg] <= cur_reg;
        if (accept)
            line_rd_reg <= line_mem[c_comb];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ew_reg         <= 24'd4096;
            nsr_reg        <= 24'd4096;
            vs_reg         <= 16'd256;
            rl_reg         <= 13'd4096;
            rc_reg         <= 16'd2;
            ul_reg         <= '0;
            left_reg       <= '0;
            cur_reg        <= '0;
            col_reg        <= '0;
            c_reg          <= '0;
            row_reg        <= '0;
            low_total_reg  <= '0;
            high_total_reg <= '0;
            low_out_reg    <= '0;
            high_out_reg   <= '0;
            out_valid_reg  <= 1'b0;
            da_reg         <= '0;
            db_reg         <= '0;
            dc_reg         <= '0;
            dd_reg         <= '0;
            mstep_reg      <= '0;
            tri_reg        <= '0;
            nsv_reg        <= '0;
            esv_reg        <= '0;
            en_reg         <= '0;
            czsq_reg       <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            len_reg        <= '{default: '0};
            g1_reg         <= '0;
            g2_reg         <= '0;
        end
        else
        begin
            // drop a taken result unless a new one is loaded this cycle
            if (out_valid_reg && out_ready &&
                !(state_reg == S_FIN && last_col && last_row))
                out_valid_reg <= 1'b0;

            // configuration writes; geometry restarts the region
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EW_RES:  ew_reg  <= cfg_data;
                    REG_NS_RES:  nsr_reg <= cfg_data;
                    REG_V_SCALE: vs_reg  <= cfg_data[15:0];
                    REG_ROW_LEN,
                    REG_ROW_CNT:
                    begin
                        if (cfg_index == REG_ROW_LEN)
                            rl_reg <= cfg_data[12:0];
                        else
                            rc_reg <= cfg_data[15:0];
                        ul_reg         <= '0;
                        left_reg       <= '0;
                        col_reg        <= '0;
                        row_reg        <= '0;
                        low_total_reg  <= '0;
                        high_total_reg <= '0;
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg   <= elevation;
                        c_reg     <= c_comb;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    da_reg    <= abs_diff(line_rd_reg, ul_reg);
                    db_reg    <= abs_diff(line_rd_reg, cur_reg);
                    dc_reg    <= abs_diff(left_reg, cur_reg);
                    dd_reg    <= abs_diff(left_reg, ul_reg);
                    ul_reg    <= line_rd_reg;
                    left_reg  <= cur_reg;
                    mstep_reg <= 3'd0;
                    tri_reg   <= 2'd0;
                    if (row_reg != 16'd0 && c_reg != '0)
                        state_reg <= S_MUL_GO;
                    else
                        state_reg <= S_FIN;
                end
                S_MUL_GO:
                    state_reg <= S_MUL_WAIT;
                S_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        case (mstep_reg)
                            3'd0:    nsv_reg  <= mul_acc[39:0];
                            3'd1:    esv_reg  <= mul_acc[39:0];
                            3'd2:    en_reg   <= mul_acc[47:0];
                            3'd3:    czsq_reg <= mul_acc[95:0];
                            3'd4:    cx_reg   <= {mul_acc[59:0], 4'd0};
                            3'd5:    cy_reg   <= {mul_acc[59:0], 4'd0};
                            default: ;
                        endcase
                        if (mstep_reg == 3'd7)
                            state_reg <= S_SQ_GO;
                        else
                        begin
                            mstep_reg <= mstep_reg + 3'd1;
                            state_reg <= S_MUL_GO;
                        end
                    end
                end
                S_SQ_GO:
                    state_reg <= S_SQ_WAIT;
                S_SQ_WAIT:
                begin
                    if (sq_done)
                    begin
                        len_reg[tri_reg] <= sq_root;
                        if (tri_reg == 2'd3)
                            state_reg <= S_SUM;
                        else
                        begin
                            tri_reg   <= tri_reg + 2'd1;
                            mstep_reg <= 3'd4;
                            state_reg <= S_MUL_GO;
                        end
                    end
                end
                S_SUM:
                begin
                    // half of the summed lengths, Q.24 to Q.16
                    g1_reg    <= sum1[LEN_W:9];
                    g2_reg    <= sum2[LEN_W:9];
                    state_reg <= S_TOTAL;
                end
                S_TOTAL:
                begin
                    if (g1_reg < g2_reg)
                    begin
                        low_total_reg  <= sat_add(low_total_reg, g1_reg);
                        high_total_reg <= sat_add(high_total_reg, g2_reg);
                    end
                    else
                    begin
                        low_total_reg  <= sat_add(low_total_reg, g2_reg);
                        high_total_reg <= sat_add(high_total_reg, g1_reg);
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (last_col && last_row)
                    begin
                        // end of region: wait for the output slot
                        if (!out_valid_reg || out_ready)
                        begin
                            low_out_reg    <= low_total_reg;
                            high_out_reg   <= high_total_reg;
                            out_valid_reg  <= 1'b1;
                            ul_reg         <= '0;
                            left_reg       <= '0;
                            col_reg        <= '0;
                            row_reg        <= '0;
                            low_total_reg  <= '0;
                            high_total_reg <= '0;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else if (last_col)
                    begin
                        col_reg   <= '0;
                        row_reg   <= row_reg + 16'd1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        col_reg   <= c_reg + CW'(1);
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign low_area  = low_out_reg;
    assign high_area = high_out_reg;

`include "assert_macros.svh"

    `SDA_ASSERT_NXT(a_busy_after_accept, accept, !in_ready)
    `SDA_ASSERT_IMP(a_mul_done_waited, mul_done, state_reg == S_MUL_WAIT)
    `SDA_ASSERT_IMP(a_sqrt_done_waited, sq_done, state_reg == S_SQ_WAIT)
    `SDA_ASSERT_IMP(a_low_le_high, 1'b1, low_total_reg <= high_total_reg)

endmodule
`default_nettype wire
